### rtl/core/mfbr_pkg.sv
package mfbr_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int POS_W        = $clog2(BUFFER_BYTES + 1);

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int LEN_W   = 7;

    localparam logic [BYTE_W-1:0] MARK_S = 8'h53;
    localparam logic [BYTE_W-1:0] MARK_T = 8'h54;
    localparam logic [BYTE_W-1:0] MARK_E = 8'h45;
    localparam logic [BYTE_W-1:0] MARK_D = 8'h44;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] PH_MARK_S = 2'd0;
    localparam logic [1:0] PH_MARK_T = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        logic               done;
        logic [LEN_W-1:0]   length;
        logic               aborted;
        logic               start;
    } frame_cmd_t;

endpackage

### rtl/core/mfbr_if.sv
interface mfbr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mfbr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [5:0] byte_index;
    logic       frame_done;
    logic [6:0] frame_length;
    logic       frame_aborted;
    logic       last;

    modport source (
        output valid, output byte_out, output byte_index, output frame_done,
        output frame_length, output frame_aborted, output last, input ready
    );
    modport sink (
        input valid, input byte_out, input byte_index, input frame_done,
        input frame_length, input frame_aborted, input last, output ready
    );
endinterface

### rtl/core/mfbr_front.sv
module mfbr_front (
    input  logic                clk,
    input  logic                rst_n,
    mfbr_byte_if.sink           byte_ch,
    input  logic                queue_full,
    output logic                push,
    output mfbr_pkg::frame_cmd_t push_cmd
);
    import mfbr_pkg::*;

    logic [BYTE_W-1:0] older_reg, older_next;
    logic [BYTE_W-1:0] newer_reg, newer_next;
    logic [1:0]        fill_reg, fill_next;
    logic              recv_reg, recv_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    logic             accept;
    logic             start;
    logic             active;
    logic             done;
    logic             aborted;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_inc;
    logic [BYTE_W-1:0] cur;

    assign byte_ch.ready = !queue_full;
    assign accept        = byte_ch.valid && !queue_full;
    assign cur           = byte_ch.rx_byte;

    assign start   = !recv_reg && (fill_reg == 2'd2) &&
                     (older_reg == MARK_S) && (newer_reg == MARK_T);
    assign active  = recv_reg || start;
    assign pos     = start ? POS_W'(2) : pos_reg;
    assign pos_inc = pos + POS_W'(1);
    assign done    = active && (newer_reg == MARK_E) && (cur == MARK_D);
    assign aborted = active && !done && (pos_inc >= POS_W'(BUFFER_BYTES));

    assign push             = accept && active;
    assign push_cmd.data    = cur;
    assign push_cmd.index   = INDEX_W'(pos);
    assign push_cmd.done    = done;
    assign push_cmd.length  = done ? LEN_W'(pos_inc) : '0;
    assign push_cmd.aborted = aborted;
    assign push_cmd.start   = start;

    always_comb
    begin
        older_next = older_reg;
        newer_next = newer_reg;
        fill_next  = fill_reg;
        recv_next  = recv_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            if (done || aborted)
            begin
                older_next = '0;
                newer_next = '0;
                fill_next  = '0;
                recv_next  = 1'b0;
                pos_next   = '0;
            end
            else
            begin
                older_next = newer_reg;
                newer_next = cur;
                if (fill_reg != 2'd2)
                begin
                    fill_next = fill_reg + 2'd1;
                end
                recv_next = active;
                if (active)
                begin
                    pos_next = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= '0;
            newer_reg <= '0;
            fill_reg  <= '0;
            recv_reg  <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            fill_reg  <= fill_next;
            recv_reg  <= recv_next;
            pos_reg   <= pos_next;
        end
    end

    a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !recv_reg |-> (pos_reg == '0))
        else $error("idle with nonzero frame position");

    a_recv_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        recv_reg |-> (pos_reg >= POS_W'(3)) && (pos_reg < POS_W'(BUFFER_BYTES)))
        else $error("frame position out of range while receiving");

endmodule

### rtl/core/mfbr_queue.sv
module mfbr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mfbr_pkg::frame_cmd_t push_cmd,
    output logic                 full,
    output logic                 head_valid,
    output mfbr_pkg::frame_cmd_t head,
    input  logic                 pop
);
    import mfbr_pkg::*;

    frame_cmd_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("transfer pushed into full queue");

endmodule

### rtl/core/mfbr_back.sv
module mfbr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  mfbr_pkg::frame_cmd_t head,
    output logic                 pop,
    mfbr_result_if.source        result_ch
);
    import mfbr_pkg::*;

    logic       valid_reg, valid_next;
    frame_cmd_t cmd_reg, cmd_next;
    logic [1:0] phase_reg, phase_next;
    logic       fire;
    logic       final_res;
    logic       load;

    assign fire      = valid_reg && result_ch.ready;
    assign final_res = (phase_reg == PH_DATA);
    assign load      = !valid_reg || (fire && final_res);
    assign pop       = load && head_valid;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = head_valid;
            cmd_next   = head;
            phase_next = head.start ? PH_MARK_S : PH_DATA;
        end
        else if (fire)
        begin
            phase_next = phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= PH_DATA;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_comb
    begin
        result_ch.byte_out      = cmd_reg.data;
        result_ch.byte_index    = cmd_reg.index;
        result_ch.frame_done    = cmd_reg.done;
        result_ch.frame_length  = cmd_reg.length;
        result_ch.frame_aborted = cmd_reg.aborted;
        result_ch.last          = 1'b1;
        case (phase_reg)
            PH_MARK_S:
            begin
                result_ch.byte_out      = MARK_S;
                result_ch.byte_index    = INDEX_W'(0);
                result_ch.frame_done    = 1'b0;
                result_ch.frame_length  = '0;
                result_ch.frame_aborted = 1'b0;
                result_ch.last          = 1'b0;
            end
            PH_MARK_T:
            begin
                result_ch.byte_out      = MARK_T;
                result_ch.byte_index    = INDEX_W'(1);
                result_ch.frame_done    = 1'b0;
                result_ch.frame_length  = '0;
                result_ch.frame_aborted = 1'b0;
                result_ch.last          = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign result_ch.valid = valid_reg;

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (phase_reg == PH_MARK_S) || (phase_reg == PH_MARK_T) ||
                      (phase_reg == PH_DATA))
        else $error("illegal burst phase");

    a_plain_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !cmd_reg.start) |-> (phase_reg == PH_DATA))
        else $error("plain entry left data phase");

endmodule

### rtl/core/marker_framed_byte_receiver_top.sv
// Marker-framed byte receiver.
// byte_ch carries received serial bytes (rx_byte); result_ch carries frame
// bytes with their buffer position, plus frame_done/frame_length on the byte
// that completes the 'E','D' end marker and frame_aborted when the buffer
// fills first. last marks the final transfer caused by one input byte.
// While idle, a byte that follows 'S','T' (with at least three bytes seen
// since reset or the previous frame end or abort) opens a frame and produces
// three transfers: 'S', 'T' and the byte itself at positions 0 to 2. Each
// further byte of the frame produces one transfer; idle bytes produce none.
// A result passes through the command queue and then the output register
// before it is presented on result_ch.
// Throughput: one byte per cycle while the queue is not full; a start burst
// holds the output for its three transfers and is absorbed by a four-entry
// command queue between the classifier and the output sequencer.
// When result_ch stalls, the queue fills and byte_ch.ready drops once it is
// full; nothing is lost. Reset (rst_n low) clears history, frame state, the
// queue and the output valid flag; no result is pending after reset.
module marker_framed_byte_receiver_top (
    input  logic          clk,
    input  logic          rst_n,
    mfbr_byte_if.sink     byte_ch,
    mfbr_result_if.source result_ch
);
    import mfbr_pkg::*;

    logic       push;
    frame_cmd_t push_cmd;
    logic       queue_full;
    logic       head_valid;
    frame_cmd_t head;
    logic       pop;

    mfbr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    mfbr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    mfbr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result_ch  (result_ch)
    );

endmodule
